/* sv/ole_pkg.sv */
// Package for the ordered list engine.
// Holds request and response types, operation and status codes, and cell control.
// No dependencies.
package ole_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FIELD_WIDTH    = 32;
    localparam int COUNT_WIDTH    = 5;

    localparam logic [2:0] KIND_ADD_HEAD     = 3'd0;
    localparam logic [2:0] KIND_ADD_TAIL     = 3'd1;
    localparam logic [2:0] KIND_INSERT_AFTER = 3'd2;
    localparam logic [2:0] KIND_DEL_HEAD     = 3'd3;
    localparam logic [2:0] KIND_DEL_TAIL     = 3'd4;
    localparam logic [2:0] KIND_SEARCH       = 3'd5;
    localparam logic [2:0] KIND_CLEAR        = 3'd6;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [2:0]                    kind;
        logic signed [FIELD_WIDTH-1:0] first_value;
        logic signed [FIELD_WIDTH-1:0] second_value;
    } t_req;

    typedef struct packed {
        logic [1:0]             status;
        logic                   found;
        logic [COUNT_WIDTH-1:0] entry_count;
    } t_rsp;

    typedef struct packed {
        logic capture;
        logic sel_match;
        logic ins_en;
        logic del_head_en;
    } t_cell_ctl;

endpackage

/* sv/ole_cell.sv */
// One position of the ordered list: holds a value and a registered key match.
// Depends on ole_pkg for the cell control struct.
module ole_cell #(
    parameter int DATA_WIDTH = ole_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  ole_pkg::t_cell_ctl    i_ctl,
    input  logic [DATA_WIDTH-1:0] i_key,
    input  logic [DATA_WIDTH-1:0] i_new_value,
    input  logic [DATA_WIDTH-1:0] i_left_value,
    input  logic [DATA_WIDTH-1:0] i_right_value,
    input  logic                  i_valid,
    input  logic                  i_next_valid,
    input  logic                  i_seen,
    input  logic                  i_seen_prev,
    output logic [DATA_WIDTH-1:0] o_value,
    output logic                  o_seen
);

    logic [DATA_WIDTH-1:0] r_value;
    logic                  r_match;
    logic                  mark;
    logic                  prev_first;

    assign mark       = i_ctl.sel_match ? r_match : (i_valid & ~i_next_valid);
    assign o_seen     = i_seen | mark;
    assign prev_first = i_seen & ~i_seen_prev;
    assign o_value    = r_value;

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_match <= i_valid && (r_value == i_key);
        end
        if (i_ctl.ins_en) begin
            if (prev_first) begin
                r_value <= i_new_value;
            end else if (i_seen) begin
                r_value <= i_left_value;
            end
        end else if (i_ctl.del_head_en) begin
            r_value <= i_right_value;
        end
    end

endmodule

/* sv/ordered_list_engine.sv */
// Ordered list engine: a bounded list of values kept in a chain of position cells.
// A request's key match is registered when it is accepted; the update and registered
// response follow once the output is free. No new request is taken while one is in work.
// Reset clears the entry count and the handshake state; cell values are not reset.
// Depends on ole_pkg and ole_cell.
module ordered_list_engine #(
    parameter int CAPACITY   = ole_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = ole_pkg::DATA_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ole_pkg::t_req i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ole_pkg::t_rsp o_out
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic               r_busy;
    logic               r_out_valid;
    ole_pkg::t_rsp      r_out;
    ole_pkg::t_rsp      n_out;
    ole_pkg::t_req      r_req;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;

    logic               accept;
    logic               done;
    logic               full;
    logic               empty;
    logic               seed;
    logic               found_any;
    logic               do_insert;
    logic               do_del_head;
    logic [DATA_WIDTH-1:0] key;
    logic [DATA_WIDTH-1:0] new_value;
    ole_pkg::t_cell_ctl ctl;

    logic [DATA_WIDTH-1:0] values [CAPACITY];
    logic [CAPACITY-1:0]   valid;
    logic [CAPACITY:0]     seen;

    assign o_in_stall  = r_busy;
    assign accept      = i_in_valid && !r_busy;
    assign done        = r_busy && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign full  = (r_count == CW'(CAPACITY));
    assign empty = (r_count == '0);
    assign key   = DATA_WIDTH'(i_in.first_value);
    assign new_value = (r_req.kind == ole_pkg::KIND_INSERT_AFTER) ?
                       DATA_WIDTH'(r_req.second_value) : DATA_WIDTH'(r_req.first_value);
    assign seed = (r_req.kind == ole_pkg::KIND_ADD_HEAD) ||
                  ((r_req.kind == ole_pkg::KIND_ADD_TAIL) && empty);
    assign seen[0]   = seed;
    assign found_any = seen[CAPACITY];

    always_comb begin
        n_out       = '0;
        n_out.status = ole_pkg::ST_OK;
        n_count     = r_count;
        do_insert   = 1'b0;
        do_del_head = 1'b0;
        unique case (r_req.kind)
            ole_pkg::KIND_ADD_HEAD, ole_pkg::KIND_ADD_TAIL: begin
                if (full) begin
                    n_out.status = ole_pkg::ST_FULL;
                end else begin
                    do_insert = 1'b1;
                    n_count   = r_count + CW'(1);
                end
            end
            ole_pkg::KIND_INSERT_AFTER: begin
                if (!found_any) begin
                    n_out.status = ole_pkg::ST_NOT_FOUND;
                end else if (full) begin
                    n_out.status = ole_pkg::ST_FULL;
                end else begin
                    do_insert = 1'b1;
                    n_count   = r_count + CW'(1);
                end
            end
            ole_pkg::KIND_DEL_HEAD, ole_pkg::KIND_DEL_TAIL: begin
                if (empty) begin
                    n_out.status = ole_pkg::ST_EMPTY;
                end else begin
                    do_del_head = (r_req.kind == ole_pkg::KIND_DEL_HEAD);
                    n_count     = r_count - CW'(1);
                end
            end
            ole_pkg::KIND_SEARCH: begin
                n_out.found = found_any;
            end
            ole_pkg::KIND_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
        n_out.entry_count = ole_pkg::COUNT_WIDTH'(n_count);
    end

    always_comb begin
        ctl.capture     = accept;
        ctl.sel_match   = (r_req.kind == ole_pkg::KIND_INSERT_AFTER) ||
                          (r_req.kind == ole_pkg::KIND_SEARCH);
        ctl.ins_en      = done && do_insert;
        ctl.del_head_en = done && do_del_head;
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [DATA_WIDTH-1:0] left_value;
            logic [DATA_WIDTH-1:0] right_value;
            logic                  next_valid;
            logic                  seen_prev;

            assign valid[g] = (r_count > CW'(g));
            if (g == 0) begin : g_first
                assign left_value = '0;
                assign seen_prev  = 1'b0;
            end else begin : g_mid
                assign left_value = values[g-1];
                assign seen_prev  = seen[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign right_value = '0;
                assign next_valid  = 1'b0;
            end else begin : g_inner
                assign right_value = values[g+1];
                assign next_valid  = valid[g+1];
            end

            ole_cell #(
                .DATA_WIDTH(DATA_WIDTH)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (ctl),
                .i_key        (key),
                .i_new_value  (new_value),
                .i_left_value (left_value),
                .i_right_value(right_value),
                .i_valid      (valid[g]),
                .i_next_valid (next_valid),
                .i_seen       (seen[g]),
                .i_seen_prev  (seen_prev),
                .o_value      (values[g]),
                .o_seen       (seen[g+1])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (done) begin
                r_busy <= 1'b0;
            end
            if (done) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_in;
        end
        if (done) begin
            r_out <= n_out;
        end
    end

endmodule

/* sv/ole_checker.sv */
// Port-level checks for the ordered list engine, bound to its top level.
// Depends on ole_pkg and ordered_list_engine.
module ole_checker #(
    parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input ole_pkg::t_rsp o_out
);

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed or dropped");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request accepted while another is in work");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.found |-> o_out.status == ole_pkg::ST_OK)
        else $error("found flag with a failing status");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == ole_pkg::ST_FULL |->
            o_out.entry_count == ole_pkg::COUNT_WIDTH'(CAPACITY))
        else $error("full status with a list that is not full");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == ole_pkg::ST_EMPTY |-> o_out.entry_count == '0)
        else $error("empty status with a list that is not empty");

endmodule

bind ordered_list_engine ole_checker #(
    .CAPACITY(CAPACITY)
) u_ole_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out      (o_out)
);
